@@ rtl/tlenc_pkg.sv @@
// Shared types, character codes and helper functions for the telemetry line encoder.
`default_nettype none

package tlenc_pkg;

   localparam int MAG_W      = 33;  // magnitude of a 33-bit signed value
   localparam int NUM_DIGITS = 10;  // decimal digits needed for 2^32
   localparam int CAP_W      = 10;
   localparam int LEN_W      = 11;
   localparam int CRC_W      = 32;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [CAP_W-1:0] CAP_RESET = 10'd256;

   // request function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_FIELD = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;

   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UA    = 8'h41;

   typedef logic [NUM_DIGITS-1:0][3:0] bcd_digits_type;

   typedef struct packed {
      logic       clear;   // new line: reset CRC, length and overflow
      logic       emit;    // one character leaves this cycle
      logic       to_crc;  // character is covered by the CRC
      logic [7:0] ch;
   } acc_cmd_type;

   // reflected CRC-32 update for one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] ch);
      logic [CRC_W-1:0] c;
      c = crc ^ {24'd0, ch};
      for (int b = 0; b < 8; b++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = CH_ZERO + {4'd0, nib};
      end else begin
         r = CH_UA + {4'd0, nib - 4'd10};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/telemetry_line_encoder_crc32.sv @@
// Top level: sequencer, output register and config register of the line encoder.
// A request's first character passes the state register, then the output register.
// Start request: 3 characters; end request: 10 characters. Ready only while idle.
// Field request: ',' and '-' go out during the BCD run, then ten digit positions,
//   one a cycle unless the output stalls, leading zeros dropped.
// Reset (synchronous, high): capacity 256, CRC all ones, length and overflow clear.
`default_nettype none

module telemetry_line_encoder_crc32 (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_func,
   input  wire logic signed [tlenc_pkg::MAG_W-1:0] req_field_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_char_out,
   output logic                             rsp_last_of_run,
   output logic                             rsp_line_bad,
   input  wire logic                        csr_write_enable,
   input  wire logic [tlenc_pkg::CAP_W-1:0] csr_write_data
);
   import tlenc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREFIX = 3'd1;
   localparam logic [2:0] S_COMMA  = 3'd2;
   localparam logic [2:0] S_SIGN   = 3'd3;
   localparam logic [2:0] S_DIGIT  = 3'd4;
   localparam logic [2:0] S_TRAIL  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [3:0]       cnt_ff, cnt_in;     // prefix / trailer character index
   logic [3:0]       dp_ff, dp_in;       // digit position, most significant first
   logic             started_ff, started_in;  // a nonzero digit has gone out
   logic             neg_ff, neg_in;
   logic [CAP_W-1:0] cap_ff;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_last_ff;
   logic             rsp_bad_ff;

   logic             accept;
   logic             slot_free;
   logic             want, fire;
   logic [7:0]       ch;
   logic             last, bad, to_crc;

   logic [MAG_W-1:0] mag;
   logic             bcd_start, bcd_busy;
   bcd_digits_type   digits;
   logic [3:0]       cur_digit;

   acc_cmd_type      acc_cmd;
   logic [CRC_W-1:0] acc_crc, crc_x;
   logic             line_bad_next;
   logic [2:0]       nib_sel;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   // output register frees up when empty or when its character is taken now
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // two's complement magnitude; -2^32 needs all 33 bits
   assign mag = req_field_value[MAG_W-1] ? MAG_W'(-req_field_value)
                                         : MAG_W'(req_field_value);
   assign bcd_start = accept & (req_func == FUNC_FIELD);

   tlenc_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .mag    (mag),
      .busy   (bcd_busy),
      .digits (digits)
   );

   assign cur_digit = digits[dp_ff];
   assign crc_x     = acc_crc ^ CRC_INIT;
   assign nib_sel   = 3'(4'd8 - cnt_ff);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      dp_in      = dp_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      want       = 1'b0;
      ch         = CH_ZERO;
      last       = 1'b0;
      bad        = 1'b0;
      to_crc     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cnt_in = '0;
               neg_in = req_field_value[MAG_W-1];
               case (req_func)
                  FUNC_START: state_in = S_PREFIX;
                  FUNC_FIELD: state_in = S_COMMA;
                  FUNC_END:   state_in = S_TRAIL;
                  default:    state_in = S_IDLE;   // unused code: dropped
               endcase
            end
         end
         S_PREFIX: begin
            want   = 1'b1;
            to_crc = 1'b1;
            ch     = (cnt_ff == 4'd0) ? CH_R : (cnt_ff == 4'd1) ? CH_D : CH_ONE;
            last   = (cnt_ff == 4'd2);
            if (slot_free) begin
               cnt_in = cnt_ff + 4'd1;
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_COMMA: begin
            want   = 1'b1;
            to_crc = 1'b1;
            ch     = CH_COMMA;
            if (slot_free) begin
               state_in   = neg_ff ? S_SIGN : S_DIGIT;
               dp_in      = 4'(NUM_DIGITS - 1);
               started_in = 1'b0;
            end
         end
         S_SIGN: begin
            want   = 1'b1;
            to_crc = 1'b1;
            ch     = CH_MINUS;
            if (slot_free) begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (!bcd_busy) begin
               if (cur_digit != 4'd0 || started_ff || dp_ff == 4'd0) begin
                  want   = 1'b1;
                  to_crc = 1'b1;
                  ch     = CH_ZERO + {4'd0, cur_digit};
                  last   = (dp_ff == 4'd0);
                  if (slot_free) begin
                     started_in = 1'b1;
                     dp_in      = dp_ff - 4'd1;
                     if (last) begin
                        state_in = S_IDLE;
                     end
                  end
               end else begin
                  dp_in = dp_ff - 4'd1;   // leading zero, skipped
               end
            end
         end
         S_TRAIL: begin
            want = 1'b1;
            last = (cnt_ff == 4'd9);
            bad  = last & line_bad_next;
            if (cnt_ff == 4'd0) begin
               ch = CH_STAR;
            end else if (last) begin
               ch = CH_NL;
            end else begin
               ch = hex_char(crc_x[{nib_sel, 2'b00} +: 4]);
            end
            if (slot_free) begin
               cnt_in = cnt_ff + 4'd1;
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign fire = want & slot_free;

   always_comb begin
      acc_cmd.clear  = accept & (req_func == FUNC_START);
      acc_cmd.emit   = fire;
      acc_cmd.to_crc = to_crc;
      acc_cmd.ch     = ch;
   end

   tlenc_acc u_acc (
      .clock         (clock),
      .reset         (reset),
      .capacity      (cap_ff),
      .cmd           (acc_cmd),
      .crc           (acc_crc),
      .line_bad_next (line_bad_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dp_ff        <= '0;
         started_ff   <= 1'b0;
         neg_ff       <= 1'b0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         dp_ff      <= dp_in;
         started_ff <= started_in;
         neg_ff     <= neg_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_char_ff <= ch;
         rsp_last_ff <= last;
         rsp_bad_ff  <= bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_line_bad    = rsp_bad_ff;

`ifndef SYNTHESIS
   a_idle_bcd_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !bcd_busy)
      else $error("converter still busy while idle");

   a_digit_after_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIGIT && fire) |-> !bcd_busy)
      else $error("digit emitted before conversion finished");

   a_bad_on_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_bad) |-> (rsp_char_out == CH_NL && rsp_last_of_run))
      else $error("line_bad flagged on a character other than the newline");

   a_start_clears_crc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_START) |=> acc_crc == CRC_INIT)
      else $error("start request did not reset the CRC");
`endif

endmodule

`default_nettype wire

@@ rtl/tlenc_bcd.sv @@
// Shift-and-add-3 binary to BCD converter, one magnitude bit per cycle.
`default_nettype none

module tlenc_bcd (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [tlenc_pkg::MAG_W-1:0] mag,
   output logic                           busy,
   output tlenc_pkg::bcd_digits_type      digits
);
   import tlenc_pkg::*;

   localparam logic [5:0] STEPS = 6'(MAG_W);

   logic [MAG_W-1:0] bin_ff, bin_in;
   bcd_digits_type   bcd_ff, bcd_in, bcd_adj;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   // add 3 to every digit of 5 or more, then shift in the next bit
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         bin_in  = mag;
         bcd_in  = '0;
         cnt_in  = STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = {bin_ff[MAG_W-2:0], 1'b0};
         bcd_in  = {bcd_adj[NUM_DIGITS-1][2:0], bcd_adj[NUM_DIGITS-2:0], bin_ff[MAG_W-1]};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign busy   = busy_ff;
   assign digits = bcd_ff;

endmodule

`default_nettype wire

@@ rtl/tlenc_acc.sv @@
// Running CRC over covered characters, line length and overflow flag, updated per emitted character.
`default_nettype none

module tlenc_acc (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [tlenc_pkg::CAP_W-1:0] capacity,
   input  wire tlenc_pkg::acc_cmd_type      cmd,
   output logic [tlenc_pkg::CRC_W-1:0]      crc,
   output logic                             line_bad_next
);
   import tlenc_pkg::*;

   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             room;

   assign room = len_ff < {1'b0, capacity};

   always_comb begin
      crc_in = crc_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (cmd.clear) begin
         crc_in = CRC_INIT;
         len_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.emit) begin
         if (room) begin
            len_in = len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (cmd.to_crc) begin
            crc_in = crc_byte(crc_ff, cmd.ch);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   assign crc           = crc_ff;
   // overflow state as it stands after the character being emitted now
   assign line_bad_next = ovf_ff | ~room;

endmodule

`default_nettype wire
